@@ rtl/lsae_pkg.sv @@
// Shared types, widths and constants for the line sensor auto exposure unit.
// No dependencies; every other rtl file refers to this package by scoped names.
`default_nettype none

package lsae_pkg;

  localparam int PIX_W   = 8;
  localparam int SUM_W   = 18;
  localparam int MEAN_W  = 8;
  localparam int VOLT_W  = 6;
  localparam int LVL_W   = 6;
  localparam int TIME_W  = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Default line length in pixels.
  localparam int LINE_PIXELS_DEF = 128;

  // mean*25/194 as (mean * 25 * ceil(2^21/194)) >> 21, exact for mean <= 255.
  localparam int VOLT_SHIFT = 21;
  localparam int VOLT_MUL_W = 19;
  localparam logic [VOLT_MUL_W-1:0] VOLT_MUL = 19'd270275;

  // Reset values.
  localparam logic [LVL_W-1:0]  TARGET_RST   = 6'd25;
  localparam logic [LVL_W-1:0]  TOL_RST      = 6'd2;
  localparam logic [LVL_W-1:0]  MAX_STEP_RST = 6'd5;
  localparam logic [TIME_W-1:0] MIN_TIME_RST = 8'd1;
  localparam logic [TIME_W-1:0] MAX_TIME_RST = 8'd100;
  localparam logic [TIME_W-1:0] TIME_RST     = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_LEVEL = 3'd0,
    CFG_TOLERANCE    = 3'd1,
    CFG_MAX_STEP     = 3'd2,
    CFG_MIN_TIME     = 3'd3,
    CFG_MAX_TIME     = 3'd4
  } lsae_cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             line_end;
  } lsae_in_t;

  typedef struct packed {
    logic [TIME_W-1:0] integration_ms;
    logic [MEAN_W-1:0] mean_pixel;
    logic [VOLT_W-1:0] mean_tenths_volt;
  } lsae_out_t;

  typedef struct packed {
    logic [LVL_W-1:0]  target_level;
    logic [LVL_W-1:0]  tolerance;
    logic [LVL_W-1:0]  max_step;
    logic [TIME_W-1:0] min_time;
    logic [TIME_W-1:0] max_time;
  } lsae_cfg_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [VOLT_W-1:0] volt;
  } lsae_level_t;

endpackage

`default_nettype wire

@@ rtl/line_sensor_auto_exposure_unit.sv @@
// Top level of the line sensor auto exposure unit: config registers and the pipeline.
// Depends on lsae_pkg, lsae_accum, lsae_scale and lsae_update.
//
// Usage:
//   in_*  : one pixel per item, valid/ready. line_end marks the last pixel of a line.
//           Pixels without line_end only add into the line sum and give no result.
//   out_* : one result per line: new integration time, mean pixel, mean in tenths
//           of a volt. valid/ready.
//   cfg_* : plain write port, one register per cycle when cfg_we is high; index
//           0 target, 1 tolerance, 2 max step, 3 min time, 4 max time; other
//           indexes are ignored. Write only while no line result is in flight.
// Throughput: one pixel per cycle while in_ready is high, line_end pixels included.
// Path: a result is presented once its accepted line_end pixel has passed the sum
//   register, mean multiply stage, volt multiply stage and result register.
// Stall: each stage has its own valid; stalled out_ready backs up stage by stage,
//   so in_ready stays high while any pipeline slot is free.
// Reset: line sum 0, integration time 10 ms, registers to their defaults, pipeline empty.
`default_nettype none

module line_sensor_auto_exposure_unit #(
  parameter int LINE_PIXELS = lsae_pkg::LINE_PIXELS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire lsae_pkg::lsae_in_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output lsae_pkg::lsae_out_t                   out_data,
  input  wire logic                             cfg_we,
  input  wire logic [lsae_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lsae_pkg::CFG_DATA_W-1:0]  cfg_data
);

  lsae_pkg::lsae_cfg_t   cfg_r, cfg_nxt;

  logic                       sum_valid, sum_ready;
  logic [lsae_pkg::SUM_W-1:0] sum_data;
  logic                       lvl_valid, lvl_ready;
  lsae_pkg::lsae_level_t      lvl_data;

  // Register file decode; 6-bit registers keep the low bits of cfg_data.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (lsae_pkg::lsae_cfg_idx_t'(cfg_index))
        lsae_pkg::CFG_TARGET_LEVEL: cfg_nxt.target_level = cfg_data[lsae_pkg::LVL_W-1:0];
        lsae_pkg::CFG_TOLERANCE:    cfg_nxt.tolerance    = cfg_data[lsae_pkg::LVL_W-1:0];
        lsae_pkg::CFG_MAX_STEP:     cfg_nxt.max_step     = cfg_data[lsae_pkg::LVL_W-1:0];
        lsae_pkg::CFG_MIN_TIME:     cfg_nxt.min_time     = cfg_data[lsae_pkg::TIME_W-1:0];
        lsae_pkg::CFG_MAX_TIME:     cfg_nxt.max_time     = cfg_data[lsae_pkg::TIME_W-1:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_level <= lsae_pkg::TARGET_RST;
      cfg_r.tolerance    <= lsae_pkg::TOL_RST;
      cfg_r.max_step     <= lsae_pkg::MAX_STEP_RST;
      cfg_r.min_time     <= lsae_pkg::MIN_TIME_RST;
      cfg_r.max_time     <= lsae_pkg::MAX_TIME_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Stage 1: running line sum, finished sum registered on line_end.
  lsae_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data)
  );

  // Stages 2 and 3: mean and voltage level.
  lsae_scale #(
    .LINE_PIXELS (LINE_PIXELS)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data),
    .lvl_valid (lvl_valid),
    .lvl_ready (lvl_ready),
    .lvl_data  (lvl_data)
  );

  // Stage 4: exposure update, holds the integration time and the result register.
  lsae_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .lvl_valid (lvl_valid),
    .lvl_ready (lvl_ready),
    .lvl_data  (lvl_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ rtl/lsae_accum.sv @@
// Line accumulator: saturating pixel sum, hands the finished line sum on.
// Depends on lsae_pkg.
`default_nettype none

module lsae_accum (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire lsae_pkg::lsae_in_t          in_data,
  output logic                             sum_valid,
  input  wire logic                        sum_ready,
  output logic [lsae_pkg::SUM_W-1:0]       sum_data
);

  logic [lsae_pkg::SUM_W-1:0] acc_r, acc_nxt;
  logic [lsae_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic                       vld_r, vld_nxt;
  logic [lsae_pkg::SUM_W:0]   add;
  logic [lsae_pkg::SUM_W-1:0] add_sat;
  logic                       take;

  assign in_ready = !vld_r || sum_ready;
  assign take     = in_valid && in_ready;
  assign add      = {1'b0, acc_r} + {{(lsae_pkg::SUM_W+1-lsae_pkg::PIX_W){1'b0}}, in_data.pixel};
  assign add_sat  = add[lsae_pkg::SUM_W] ? '1 : add[lsae_pkg::SUM_W-1:0];

  always_comb begin
    acc_nxt = acc_r;
    sum_nxt = sum_r;
    vld_nxt = vld_r && !sum_ready;
    if (take) begin
      if (in_data.line_end) begin
        acc_nxt = '0;
        sum_nxt = add_sat;
        vld_nxt = 1'b1;
      end else begin
        acc_nxt = add_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      vld_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      vld_r <= vld_nxt;
    end
    sum_r <= sum_nxt;
  end

  assign sum_valid = vld_r;
  assign sum_data  = sum_r;

endmodule

`default_nettype wire

@@ rtl/lsae_scale.sv @@
// Two-stage scaler: line sum -> mean (reciprocal multiply), mean -> tenths of a volt.
// Depends on lsae_pkg.
`default_nettype none

module lsae_scale #(
  parameter int LINE_PIXELS = lsae_pkg::LINE_PIXELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        sum_valid,
  output logic                             sum_ready,
  input  wire logic [lsae_pkg::SUM_W-1:0]  sum_data,
  output logic                             lvl_valid,
  input  wire logic                        lvl_ready,
  output lsae_pkg::lsae_level_t            lvl_data
);

  // floor(x/N) = (x * ceil(2^K/N)) >> K, exact for x < 2^SUM_W with K = SUM_W + clog2(N).
  localparam int          DIV_SHIFT  = lsae_pkg::SUM_W + $clog2(LINE_PIXELS);
  localparam int unsigned MEAN_RECIP = ((1 << DIV_SHIFT) + LINE_PIXELS - 1) / LINE_PIXELS;
  localparam int          RECIP_W    = 20;
  localparam int          PROD_W     = lsae_pkg::SUM_W + RECIP_W;
  localparam int          QUOT_W     = PROD_W - DIV_SHIFT;
  localparam int          VPROD_W    = lsae_pkg::MEAN_W + lsae_pkg::VOLT_MUL_W;

  logic [PROD_W-1:0]           prod;
  logic [QUOT_W-1:0]           quot;
  logic [lsae_pkg::MEAN_W-1:0] mean_sat;
  logic [VPROD_W-1:0]          vprod;

  logic                        m_vld_r;
  logic [lsae_pkg::MEAN_W-1:0] m_mean_r;
  logic                        l_vld_r;
  lsae_pkg::lsae_level_t       l_data_r;
  logic                        m_ready;

  assign prod     = {{RECIP_W{1'b0}}, sum_data} * {{lsae_pkg::SUM_W{1'b0}}, RECIP_W'(MEAN_RECIP)};
  assign quot     = prod[PROD_W-1:DIV_SHIFT];
  assign mean_sat = (quot > QUOT_W'(255)) ? '1 : quot[lsae_pkg::MEAN_W-1:0];

  assign vprod = {{lsae_pkg::VOLT_MUL_W{1'b0}}, m_mean_r}
               * {{lsae_pkg::MEAN_W{1'b0}}, lsae_pkg::VOLT_MUL};

  assign m_ready   = !l_vld_r || lvl_ready;
  assign sum_ready = !m_vld_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      l_vld_r <= 1'b0;
    end else begin
      if (sum_ready) begin
        m_vld_r <= sum_valid;
      end
      if (m_ready) begin
        l_vld_r <= m_vld_r;
      end
    end
    if (sum_ready && sum_valid) begin
      m_mean_r <= mean_sat;
    end
    if (m_ready && m_vld_r) begin
      l_data_r.mean <= m_mean_r;
      l_data_r.volt <= vprod[lsae_pkg::VOLT_SHIFT +: lsae_pkg::VOLT_W];
    end
  end

  assign lvl_valid = l_vld_r;
  assign lvl_data  = l_data_r;

endmodule

`default_nettype wire

@@ rtl/lsae_update.sv @@
// Integration time update and result register.
// Depends on lsae_pkg.
`default_nettype none

module lsae_update (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lsae_pkg::lsae_cfg_t    cfg,
  input  wire logic                   lvl_valid,
  output logic                        lvl_ready,
  input  wire lsae_pkg::lsae_level_t  lvl_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output lsae_pkg::lsae_out_t         out_data
);

  logic [lsae_pkg::TIME_W-1:0] time_r;
  logic [lsae_pkg::TIME_W-1:0] time_nxt;
  logic                        vld_r;
  lsae_pkg::lsae_out_t         data_r;

  logic signed [9:0] err, tol_s, mag, half, step, t_adj, t_lo;

  assign lvl_ready = !vld_r || out_ready;

  always_comb begin
    err   = $signed({4'b0, cfg.target_level}) - $signed({4'b0, lvl_data.volt});
    tol_s = $signed({4'b0, cfg.tolerance});
    mag   = (err < 0) ? -err : err;
    half  = mag >>> 1;
    step  = (half > $signed({4'b0, cfg.max_step})) ? $signed({4'b0, cfg.max_step}) : half;
    t_adj = $signed({2'b0, time_r});
    if (err < -tol_s) begin
      t_adj = t_adj - step;
    end else if (err > tol_s) begin
      t_adj = t_adj + step;
    end
    // lower limit first, upper limit wins when the limits cross
    t_lo = (t_adj <= $signed({2'b0, cfg.min_time})) ? $signed({2'b0, cfg.min_time}) : t_adj;
    if (t_lo >= $signed({2'b0, cfg.max_time})) begin
      time_nxt = cfg.max_time;
    end else begin
      time_nxt = t_lo[lsae_pkg::TIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      time_r <= lsae_pkg::TIME_RST;
    end else begin
      if (lvl_ready) begin
        vld_r <= lvl_valid;
      end
      if (lvl_ready && lvl_valid) begin
        time_r <= time_nxt;
      end
    end
    if (lvl_ready && lvl_valid) begin
      data_r.integration_ms   <= time_nxt;
      data_r.mean_pixel       <= lvl_data.mean;
      data_r.mean_tenths_volt <= lvl_data.volt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire
